### hdl/mwss_pkg.sv
// shared types and constants for the maximum window sum block
package mwss_pkg;

	// fixed widths of the register file and the result beat
	localparam int SIDE_CFG_BITS   = 7;
	localparam int WINDOW_CFG_BITS = 5;
	localparam int CFG_DATA_BITS   = 7;
	localparam int CFG_INDEX_BITS  = 1;
	localparam int SUM_BITS        = 24;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_MATRIX_SIDE = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SIDE = 1'd1;

	// saturation limits of a window sum
	localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
	localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

	// queue depths
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 8;

	// what the front part works out for one element
	typedef struct packed {
		logic found;       // window fits in the matrix
		logic last;        // last element of the matrix
		logic window_end;  // a complete window ends here
		logic first_row;   // column sum starts from zero
		logic sub_line;    // element leaving the column window is subtracted
		logic first_col;   // row sum starts from this column
		logic sub_left;    // column sum leaving the row window is subtracted
	} mwss_flags_t;

endpackage

### hdl/mwss_queue.sv
// small register queue with push and pop sides
module mwss_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           push_data,
	input  logic                       pop,
	output logic [WIDTH-1:0]           pop_data,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign count    = count_q;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### hdl/mwss_front.sv
// front part: row and column tracking and per-element classification
module mwss_front import mwss_pkg::*; #(
	parameter int MAX_SIDE     = 64,
	parameter int MAX_WINDOW   = 16,
	parameter int ELEMENT_BITS = 16
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               restart,
	input  logic [SIDE_CFG_BITS-1:0]                           matrix_side,
	input  logic [WINDOW_CFG_BITS-1:0]                         window_side,
	input  logic                                               push,
	input  logic                                               full,
	input  logic signed [ELEMENT_BITS-1:0]                     element_value,
	output logic                                               q_push,
	output logic signed [ELEMENT_BITS-1:0]                     q_value,
	output logic [$clog2(MAX_SIDE)-1:0]                        q_col,
	output logic [$clog2(MAX_WINDOW*MAX_SIDE)-1:0]             q_addr,
	output mwss_flags_t                                        q_flags,
	output logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] win_m1
);

	localparam int CNT_W  = $clog2(MAX_SIDE);
	localparam int NW     = $clog2(MAX_SIDE + 1);
	localparam int WW     = $clog2(MAX_WINDOW + 1);
	localparam int CW     = ((NW > WW) ? NW : WW) + 1;
	localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int LS_AW  = $clog2(MAX_WINDOW * MAX_SIDE);

	logic [CNT_W-1:0]  row_q;
	logic [CNT_W-1:0]  col_q;
	logic [SLOT_W-1:0] slot_q;
	logic [NW-1:0]     side_n;
	logic [WW-1:0]     win_w;
	logic [CW-1:0]     r_x, c_x, n_x, w_x;
	logic              row_last;
	logic              col_last;
	logic              accept;

	// out-of-range settings fold onto the nearest legal value
	always_comb begin
		if (matrix_side == '0) begin
			side_n = NW'(1);
		end else if (int'(matrix_side) > MAX_SIDE) begin
			side_n = NW'(MAX_SIDE);
		end else begin
			side_n = NW'(matrix_side);
		end
		if (window_side == '0) begin
			win_w = WW'(1);
		end else if (int'(window_side) > MAX_WINDOW) begin
			win_w = WW'(MAX_WINDOW);
		end else begin
			win_w = WW'(window_side);
		end
	end

	assign r_x = CW'(row_q);
	assign c_x = CW'(col_q);
	assign n_x = CW'(side_n);
	assign w_x = CW'(win_w);

	assign row_last = (r_x == n_x - CW'(1));
	assign col_last = (c_x == n_x - CW'(1));
	assign win_m1   = SLOT_W'(win_w - WW'(1));
	assign accept   = push && !full;

	assign q_push  = accept;
	assign q_value = element_value;
	assign q_col   = col_q;
	assign q_addr  = LS_AW'(slot_q) * LS_AW'(MAX_SIDE) + LS_AW'(col_q);

	always_comb begin
		q_flags.found      = (w_x <= n_x);
		q_flags.last       = row_last && col_last;
		q_flags.window_end = (w_x <= n_x) && (r_x + CW'(1) >= w_x) && (c_x + CW'(1) >= w_x);
		q_flags.first_row  = (row_q == '0);
		q_flags.sub_line   = (r_x >= w_x);
		q_flags.first_col  = (col_q == '0);
		q_flags.sub_left   = (c_x >= w_x);
	end

	// slot_q is the row number modulo the window, selecting the line store row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
		end else if (restart) begin
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if (row_last && col_last) begin
				row_q  <= '0;
				col_q  <= '0;
				slot_q <= '0;
			end else if (col_last) begin
				row_q  <= row_q + CNT_W'(1);
				col_q  <= '0;
				slot_q <= (slot_q == win_m1) ? '0 : slot_q + SLOT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

endmodule

### hdl/mwss_back.sv
// back part: line store, column sums, row sliding sum and running maximum
module mwss_back import mwss_pkg::*; #(
	parameter int MAX_SIDE     = 64,
	parameter int MAX_WINDOW   = 16,
	parameter int ELEMENT_BITS = 16
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               restart,
	input  logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] win_m1,
	input  logic                                               q_empty,
	input  logic signed [ELEMENT_BITS-1:0]                     q_value,
	input  logic [$clog2(MAX_SIDE)-1:0]                        q_col,
	input  logic [$clog2(MAX_WINDOW*MAX_SIDE)-1:0]             q_addr,
	input  mwss_flags_t                                        q_flags,
	output logic                                               q_pop,
	input  logic [$clog2(OUT_DEPTH+1)-1:0]                     out_count,
	output logic                                               res_push,
	output logic signed [SUM_BITS-1:0]                         res_best,
	output logic                                               res_found
);

	localparam int CNT_W  = $clog2(MAX_SIDE);
	localparam int LS_AW  = $clog2(MAX_WINDOW * MAX_SIDE);
	localparam int WB     = $clog2(MAX_WINDOW);
	localparam int COL_W  = ELEMENT_BITS + WB;
	localparam int COLX_W = COL_W + 1;
	localparam int ROW_W  = ELEMENT_BITS + 2 * WB + 1;
	localparam int CMP_W  = (ROW_W > SUM_BITS) ? ROW_W : SUM_BITS;
	localparam int OCW    = $clog2(OUT_DEPTH + 1);
	localparam int OCX_W  = OCW + 1;

	// memories
	logic signed [ELEMENT_BITS-1:0] line_mem [MAX_WINDOW * MAX_SIDE];
	logic signed [COL_W-1:0]        col_mem  [MAX_SIDE];

	// stage 1: memory read data and forwarding
	logic                           v_s1;
	mwss_flags_t                    flags_s1;
	logic signed [ELEMENT_BITS-1:0] value_s1;
	logic [CNT_W-1:0]               col_s1;
	logic [LS_AW-1:0]               addr_s1;
	logic signed [ELEMENT_BITS-1:0] line_rd_s1;
	logic signed [COL_W-1:0]        col_rd_s1;
	logic                           fwd_col_s1;
	logic                           fwd_line_s1;
	logic signed [COL_W-1:0]        col_last_q;
	logic signed [ELEMENT_BITS-1:0] line_last_q;
	logic signed [COL_W-1:0]        col_old;
	logic signed [ELEMENT_BITS-1:0] line_old;
	logic signed [COLX_W-1:0]       col_sum_x;
	logic signed [COL_W-1:0]        col_new;

	// stage 2: row sliding sum
	logic                    v_s2;
	mwss_flags_t             flags_s2;
	logic signed [COL_W-1:0] colsum_s2;
	logic signed [COL_W-1:0] taps_q [MAX_WINDOW];
	logic signed [ROW_W-1:0] row_q;
	logic signed [ROW_W-1:0] row_base;
	logic signed [COL_W-1:0] left;
	logic signed [ROW_W-1:0] row_next;

	// stage 3: saturation and maximum
	logic                       v_s3;
	mwss_flags_t                flags_s3;
	logic signed [ROW_W-1:0]    row_s3;
	logic signed [CMP_W-1:0]    cand_x;
	logic signed [CMP_W-1:0]    lim_max_x;
	logic signed [CMP_W-1:0]    lim_min_x;
	logic signed [SUM_BITS-1:0] cand;
	logic signed [SUM_BITS-1:0] cand_eff;
	logic signed [SUM_BITS-1:0] new_max;
	logic signed [SUM_BITS-1:0] max_q;

	logic [OCX_W-1:0] pending;

	// take a beat only when every result in flight is sure of an output slot
	assign pending = OCX_W'(v_s1 && flags_s1.last) + OCX_W'(v_s2 && flags_s2.last)
		+ OCX_W'(v_s3 && flags_s3.last);
	assign q_pop = !q_empty && ((OCX_W'(out_count) + pending) < OCX_W'(OUT_DEPTH));

	// stage 1 capture; a write from the element ahead lands too late for this read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		line_rd_s1  <= line_mem[q_addr];
		col_rd_s1   <= col_mem[q_col];
		flags_s1    <= q_flags;
		value_s1    <= q_value;
		col_s1      <= q_col;
		addr_s1     <= q_addr;
		fwd_col_s1  <= v_s1 && (col_s1 == q_col);
		fwd_line_s1 <= v_s1 && (addr_s1 == q_addr);
		col_last_q  <= col_new;
		line_last_q <= value_s1;
	end

	always_comb begin
		line_old  = fwd_line_s1 ? line_last_q : line_rd_s1;
		col_old   = flags_s1.first_row ? '0 : (fwd_col_s1 ? col_last_q : col_rd_s1);
		col_sum_x = COLX_W'(col_old) + COLX_W'(value_s1)
			- (flags_s1.sub_line ? COLX_W'(line_old) : COLX_W'(0));
		col_new   = COL_W'(col_sum_x);
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			line_mem[addr_s1] <= value_s1;
			col_mem[col_s1]   <= col_new;
		end
	end

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		flags_s2  <= flags_s1;
		colsum_s2 <= col_new;
	end

	always_comb begin
		row_base = flags_s2.first_col ? ROW_W'(0) : row_q;
		left     = flags_s2.sub_left ? taps_q[win_m1] : COL_W'(0);
		row_next = row_base + ROW_W'(colsum_s2) - ROW_W'(left);
	end

	// taps hold the column sums of the preceding elements, newest first
	always_ff @(posedge clk) begin
		if (v_s2) begin
			row_q     <= row_next;
			taps_q[0] <= colsum_s2;
			for (int i = 1; i < MAX_WINDOW; i++) begin
				taps_q[i] <= taps_q[i-1];
			end
		end
	end

	// stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		flags_s3 <= flags_s2;
		row_s3   <= row_next;
	end

	always_comb begin
		cand_x    = CMP_W'(row_s3);
		lim_max_x = CMP_W'(SUM_MAX);
		lim_min_x = CMP_W'(SUM_MIN);
		priority if (cand_x > lim_max_x) begin
			cand = SUM_MAX;
		end else if (cand_x < lim_min_x) begin
			cand = SUM_MIN;
		end else begin
			cand = SUM_BITS'(row_s3);
		end
		cand_eff = flags_s3.window_end ? cand : SUM_MIN;
		new_max  = (cand_eff > max_q) ? cand_eff : max_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= SUM_MIN;
		end else if (restart) begin
			max_q <= SUM_MIN;
		end else if (v_s3) begin
			max_q <= flags_s3.last ? SUM_MIN : new_max;
		end
	end

	assign res_push  = v_s3 && flags_s3.last;
	assign res_best  = flags_s3.found ? new_max : SUM_MIN;
	assign res_found = flags_s3.found;

endmodule

### hdl/max_window_sum_square_top.sv
// top level of the maximum window sum block: registers, queues and assertions
//
// streams a square matrix in row-major order, one element per push beat, and
// after its last element delivers one result beat: the largest sum over all
// window_side x window_side submatrices (saturated to 24 bits) and a flag that
// is low when the window does not fit, in which case best_sum is the most
// negative value. a new element is taken in every cycle while full is low, also
// while a result still waits to be popped; the sustained rate is one element per
// clock while full stays low. the last element's result reaches the output
// through the element queue together with the line store and column sum read,
// column update, row sliding sum, then saturate and compare. the back part
// draws elements from the queue only when the output queue has room for every
// result in flight, so a result left unpopped for long holds push back through
// full.
// a write to either register restarts the matrix; write them only when the
// block is idle. out-of-range settings fold to 1 or to the largest supported
// value. the line store and column sums need no clearing pass after reset:
// the first row of every matrix starts the column sums from zero.
module max_window_sum_square_top import mwss_pkg::*; #(
	parameter int MAX_SIDE     = 64,
	parameter int MAX_WINDOW   = 16,
	parameter int ELEMENT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic signed [ELEMENT_BITS-1:0] element_value,
	output logic                           empty,
	input  logic                           pop,
	output logic signed [SUM_BITS-1:0]     best_sum,
	output logic                           window_found,
	input  logic                           cfg_write,
	input  logic [CFG_INDEX_BITS-1:0]      cfg_index,
	input  logic [CFG_DATA_BITS-1:0]       cfg_data
);

	localparam int CNT_W   = $clog2(MAX_SIDE);
	localparam int LS_AW   = $clog2(MAX_WINDOW * MAX_SIDE);
	localparam int SLOT_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int FLAGS_W = $bits(mwss_flags_t);
	localparam int MID_W   = ELEMENT_BITS + CNT_W + LS_AW + FLAGS_W;
	localparam int RES_W   = SUM_BITS + 1;
	localparam int OCW     = $clog2(OUT_DEPTH + 1);

	// configuration registers
	logic [SIDE_CFG_BITS-1:0]   matrix_side_q;
	logic [WINDOW_CFG_BITS-1:0] window_side_q;

	// front to element queue
	logic                           f_push;
	logic signed [ELEMENT_BITS-1:0] f_value;
	logic [CNT_W-1:0]               f_col;
	logic [LS_AW-1:0]               f_addr;
	mwss_flags_t                    f_flags;
	logic [SLOT_W-1:0]              win_m1;

	// element queue to back
	logic [MID_W-1:0]               mid_data;
	logic                           mid_full;
	logic                           mid_empty;
	logic                           mid_pop;
	logic signed [ELEMENT_BITS-1:0] b_value;
	logic [CNT_W-1:0]               b_col;
	logic [LS_AW-1:0]               b_addr;
	mwss_flags_t                    b_flags;

	// back to result queue
	logic                       res_push;
	logic signed [SUM_BITS-1:0] res_best;
	logic                       res_found;
	logic [RES_W-1:0]           out_data;
	logic                       out_full;
	logic [OCW-1:0]             out_count;

	// any register write restarts the matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_side_q <= SIDE_CFG_BITS'(8);
			window_side_q <= WINDOW_CFG_BITS'(2);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MATRIX_SIDE: matrix_side_q <= cfg_data[SIDE_CFG_BITS-1:0];
				REG_WINDOW_SIDE: window_side_q <= cfg_data[WINDOW_CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// front: counts rows and columns, tags each element
	mwss_front #(
		.MAX_SIDE     (MAX_SIDE),
		.MAX_WINDOW   (MAX_WINDOW),
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.restart       (cfg_write),
		.matrix_side   (matrix_side_q),
		.window_side   (window_side_q),
		.push          (push),
		.full          (mid_full),
		.element_value (element_value),
		.q_push        (f_push),
		.q_value       (f_value),
		.q_col         (f_col),
		.q_addr        (f_addr),
		.q_flags       (f_flags),
		.win_m1        (win_m1)
	);

	// element queue decoupling the front from the back
	mwss_queue #(
		.WIDTH (MID_W),
		.DEPTH (MID_DEPTH)
	) u_mid_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data ({f_value, f_col, f_addr, f_flags}),
		.pop       (mid_pop),
		.pop_data  (mid_data),
		.full      (mid_full),
		.empty     (mid_empty),
		.count     ()
	);

	assign {b_value, b_col, b_addr, b_flags} = mid_data;

	// back: sums, maximum and result
	mwss_back #(
		.MAX_SIDE     (MAX_SIDE),
		.MAX_WINDOW   (MAX_WINDOW),
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (cfg_write),
		.win_m1    (win_m1),
		.q_empty   (mid_empty),
		.q_value   (b_value),
		.q_col     (b_col),
		.q_addr    (b_addr),
		.q_flags   (b_flags),
		.q_pop     (mid_pop),
		.out_count (out_count),
		.res_push  (res_push),
		.res_best  (res_best),
		.res_found (res_found)
	);

	// result queue
	mwss_queue #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data ({res_best, res_found}),
		.pop       (pop),
		.pop_data  (out_data),
		.full      (out_full),
		.empty     (empty),
		.count     (out_count)
	);

	assign full         = mid_full;
	assign best_sum     = out_data[RES_W-1:1];
	assign window_found = out_data[0];

`ifndef SYNTHESIS
	// room check in the back must keep the result queue from overflowing
	assert property (@(posedge clk) disable iff (!arst_n) !(res_push && out_full))
		else $error("result beat pushed into a full result queue");

	// the back never draws from an empty element queue
	assert property (@(posedge clk) disable iff (!arst_n) mid_pop |-> !mid_empty)
		else $error("element queue popped while empty");

	// a result without a fitting window carries the most negative sum
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !window_found) |-> (best_sum == SUM_MIN))
		else $error("no-window result carries a sum");
`endif

endmodule
